// ----- rtl/core/bmp24_pkg.sv -----
// Shared types and constants for the 24-bit BMP stream decoder.
package bmp24_pkg;

   localparam int DIM_BITS = 16;

   localparam logic [5:0]  HEADER_LAST  = 6'd53;
   localparam logic [5:0]  WIDTH_FIRST  = 6'd18;
   localparam logic [5:0]  WIDTH_LAST   = 6'd21;
   localparam logic [5:0]  HEIGHT_FIRST = 6'd22;
   localparam logic [5:0]  HEIGHT_LAST  = 6'd25;
   localparam logic [5:0]  DEPTH_LOW    = 6'd28;
   localparam logic [5:0]  DEPTH_HIGH   = 6'd29;
   localparam logic [15:0] DEPTH_24     = 16'd24;

   localparam logic STATUS_PIXEL = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [3:0] {
      PHASE_HEADER = 4'b0001,
      PHASE_PIXEL  = 4'b0010,
      PHASE_PAD    = 4'b0100,
      PHASE_IDLE   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      LANE_BLUE  = 2'd0,
      LANE_GREEN = 2'd1,
      LANE_RED   = 2'd2
   } lane_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_payload_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] row_index;
      logic [15:0] column_index;
      logic        last_pixel;
   } rsp_payload_type;

endpackage

// ----- rtl/core/bmp24_parser.sv -----
// Header capture, format check and pixel assembly for the BMP byte stream.
module bmp24_parser
   import bmp24_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  req_payload_type req_data,
   output logic            res_valid,
   output rsp_payload_type res_data
);

   logic [5:0]          pos_ff, pos_in, pos_eff;
   phase_type           phase_ff, phase_in, phase_eff;
   logic [31:0]         width_ff, width_in, width_eff;
   logic [31:0]         height_ff, height_in, height_eff;
   logic [15:0]         depth_ff, depth_in, depth_eff;
   lane_type            lane_ff, lane_in;
   logic [7:0]          blue_ff, blue_in;
   logic [7:0]          green_ff, green_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic [1:0]          pad_ff, pad_in;

   logic [1:0]          wh_lane;
   logic [4:0]          wh_shift;
   logic [31:0]         byte_wide;
   logic                bad_format;
   logic                empty_image;
   logic                col_last;
   logic                row_last;
   logic [31:0]         row_wide;
   logic [31:0]         col_wide;
   logic [1:0]          pad_dec;

   // start of file restarts parsing at header byte zero
   always_comb begin
      pos_eff    = req_data.start_of_file ? '0 : pos_ff;
      phase_eff  = req_data.start_of_file ? PHASE_HEADER : phase_ff;
      width_eff  = req_data.start_of_file ? '0 : width_ff;
      height_eff = req_data.start_of_file ? '0 : height_ff;
      depth_eff  = req_data.start_of_file ? '0 : depth_ff;
   end

   assign wh_lane   = pos_eff[1:0] - 2'd2;
   assign wh_shift  = {wh_lane, 3'b000};
   assign byte_wide = 32'(req_data.data_byte);

   assign bad_format  = (depth_eff != DEPTH_24) || ((width_eff >> DIM_BITS) != '0) ||
                        ((height_eff >> DIM_BITS) != '0);
   assign empty_image = (width_eff == '0) || (height_eff == '0);

   assign col_last = (col_ff == (DIM_BITS'(width_ff) - 1'b1));
   assign row_last = (row_ff == (DIM_BITS'(height_ff) - 1'b1));
   assign row_wide = 32'(row_ff);
   assign col_wide = 32'(col_ff);
   assign pad_dec  = pad_ff - 2'd1;

   always_comb begin
      pos_in    = pos_eff;
      phase_in  = phase_eff;
      width_in  = width_eff;
      height_in = height_eff;
      depth_in  = depth_eff;
      lane_in   = lane_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;
      res_valid = 1'b0;
      res_data  = '0;

      case (phase_eff)
         PHASE_HEADER: begin
            if (pos_eff >= WIDTH_FIRST && pos_eff <= WIDTH_LAST) begin
               width_in = width_eff | (byte_wide << wh_shift);
            end else if (pos_eff >= HEIGHT_FIRST && pos_eff <= HEIGHT_LAST) begin
               height_in = height_eff | (byte_wide << wh_shift);
            end else if (pos_eff == DEPTH_LOW) begin
               depth_in = {depth_eff[15:8], req_data.data_byte};
            end else if (pos_eff == DEPTH_HIGH) begin
               depth_in = {req_data.data_byte, depth_eff[7:0]};
            end
            if (pos_eff != HEADER_LAST) begin
               pos_in = pos_eff + 6'd1;
            end else begin
               pos_in = '0;
               if (bad_format) begin
                  phase_in        = PHASE_IDLE;
                  res_valid       = 1'b1;
                  res_data.status = STATUS_ERROR;
               end else if (empty_image) begin
                  phase_in = PHASE_IDLE;
               end else begin
                  phase_in = PHASE_PIXEL;
                  lane_in  = LANE_BLUE;
                  col_in   = '0;
                  row_in   = '0;
               end
            end
         end
         PHASE_PIXEL: begin
            case (lane_ff)
               LANE_BLUE: begin
                  blue_in = req_data.data_byte;
                  lane_in = LANE_GREEN;
               end
               LANE_GREEN: begin
                  green_in = req_data.data_byte;
                  lane_in  = LANE_RED;
               end
               default: begin
                  lane_in               = LANE_BLUE;
                  res_valid             = 1'b1;
                  res_data.status       = STATUS_PIXEL;
                  res_data.red          = req_data.data_byte;
                  res_data.green        = green_ff;
                  res_data.blue         = blue_ff;
                  res_data.row_index    = row_wide[15:0];
                  res_data.column_index = col_wide[15:0];
                  if (col_last && row_last) begin
                     res_data.last_pixel = 1'b1;
                     phase_in            = PHASE_IDLE;
                  end else if (col_last) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                     pad_in = width_ff[1:0];
                     if (width_ff[1:0] != 2'd0) begin
                        phase_in = PHASE_PAD;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            endcase
         end
         PHASE_PAD: begin
            pad_in = pad_dec;
            if (pad_dec == 2'd0) begin
               phase_in = PHASE_PIXEL;
            end
         end
         default: begin
            phase_in = phase_eff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PHASE_HEADER;
         width_ff  <= '0;
         height_ff <= '0;
         depth_ff  <= '0;
         lane_ff   <= LANE_BLUE;
         col_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= '0;
      end else if (take) begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         lane_ff   <= lane_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

endmodule

// ----- rtl/core/bmp24_rsp_queue.sv -----
// Two-entry result register with skid slot for the response channel.
module bmp24_rsp_queue
   import bmp24_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  rsp_payload_type push_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            head_valid_ff, head_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type head_ff, head_in;
   rsp_payload_type skid_ff, skid_in;
   logic            pop;

   assign pop         = head_valid_ff && rsp_ready;
   assign rsp_valid   = head_valid_ff;
   assign rsp_payload = head_ff;
   assign full        = skid_valid_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      // advance the skid entry into the head on a transfer
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!head_valid_in) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- rtl/core/bmp24_stream_decoder_unit.sv -----
// Top level of the 24-bit uncompressed BMP stream decoder.
//
// The block takes one file byte per req_ transfer and may take a byte in
// every cycle while req_ready is high, each in a single pass through the
// parser logic into its state registers. Bytes 0 to 53 form the header;
// width (bytes 18..21), height (22..25) and bits per pixel (28..29) are
// captured little-endian. At header byte 53 a bad format (depth not 24, or
// a dimension that does not fit DIM_BITS) yields one result with status 1
// and all other fields zero; an empty image yields nothing. After that each
// blue, green, red triple yields one pixel result with its row (bottom row
// first) and column, row pad bytes are skipped, and the final pixel carries
// last_pixel. Bytes after the end, or after an error, are dropped until a
// byte arrives with start_of_file set, which restarts parsing with that byte
// as header byte 0. Results sit in a two-entry output queue, so req_ready
// stays high while one result waits on rsp_ready and drops only when both
// entries are occupied. Each result passes through a queue register to rsp_.
module bmp24_stream_decoder_unit
   import bmp24_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            take;
   logic            res_valid;
   rsp_payload_type res_data;
   logic            push;
   logic            queue_full;

   // hold off input only while the skid slot is occupied
   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;
   assign push      = take && res_valid;

   bmp24_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_data  (req_payload),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   bmp24_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (queue_full),
      .push_data   (res_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- verif/bmp24_decode_checker.sv -----
// Result checker for the BMP decoder: decodes the accepted byte stream itself and compares.
`timescale 1ns / 100ps
module bmp24_decode_checker
   import bmp24_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              failures,
   output int              outstanding
);

   logic [5:0]  hdr_pos;
   phase_type   phase;
   logic [31:0] img_w;
   logic [31:0] img_h;
   logic [15:0] bpp;
   lane_type    lane;
   logic [7:0]  held_b;
   logic [7:0]  held_g;
   logic [15:0] col;
   logic [15:0] row;
   logic [1:0]  pad_left;
   int          fail_count = 0;

   rsp_payload_type decoded_results[$];

   task automatic clear_parse();
      hdr_pos  = '0;
      phase    = PHASE_HEADER;
      img_w    = '0;
      img_h    = '0;
      bpp      = '0;
      lane     = LANE_BLUE;
      held_b   = '0;
      held_g   = '0;
      col      = '0;
      row      = '0;
      pad_left = '0;
   endtask

   // Advance the decoder by one byte; queue the result it gives, if any.
   task automatic decode_byte(input req_payload_type item);
      rsp_payload_type res;
      logic [7:0]      b;
      b = item.data_byte;
      res = '0;
      if (item.start_of_file)
         clear_parse();
      case (phase)
         PHASE_HEADER: begin
            if (hdr_pos >= WIDTH_FIRST && hdr_pos <= WIDTH_LAST)
               img_w = img_w | (32'(b) << (8 * (hdr_pos - WIDTH_FIRST)));
            else if (hdr_pos >= HEIGHT_FIRST && hdr_pos <= HEIGHT_LAST)
               img_h = img_h | (32'(b) << (8 * (hdr_pos - HEIGHT_FIRST)));
            else if (hdr_pos >= DEPTH_LOW && hdr_pos <= DEPTH_HIGH)
               bpp = bpp | (16'(b) << (8 * (hdr_pos - DEPTH_LOW)));
            if (hdr_pos != HEADER_LAST) begin
               hdr_pos = hdr_pos + 6'd1;
            end else begin
               hdr_pos = '0;
               if (bpp != DEPTH_24 || (img_w >> DIM_BITS) != 0 || (img_h >> DIM_BITS) != 0) begin
                  phase = PHASE_IDLE;
                  res.status = STATUS_ERROR;
                  decoded_results.push_back(res);
               end else if (img_w == 0 || img_h == 0) begin
                  phase = PHASE_IDLE;
               end else begin
                  phase = PHASE_PIXEL;
                  lane  = LANE_BLUE;
                  col   = '0;
                  row   = '0;
               end
            end
         end
         PHASE_PIXEL: begin
            case (lane)
               LANE_BLUE: begin
                  held_b = b;
                  lane   = LANE_GREEN;
               end
               LANE_GREEN: begin
                  held_g = b;
                  lane   = LANE_RED;
               end
               default: begin
                  lane             = LANE_BLUE;
                  res.status       = STATUS_PIXEL;
                  res.red          = b;
                  res.green        = held_g;
                  res.blue         = held_b;
                  res.row_index    = row;
                  res.column_index = col;
                  if (32'(col) + 32'd1 >= img_w) begin
                     if (32'(row) + 32'd1 >= img_h) begin
                        res.last_pixel = 1'b1;
                        phase = PHASE_IDLE;
                     end else begin
                        col      = '0;
                        row      = row + 16'd1;
                        pad_left = img_w[1:0];
                        if (pad_left != 2'd0)
                           phase = PHASE_PAD;
                     end
                  end else begin
                     col = col + 16'd1;
                  end
                  decoded_results.push_back(res);
               end
            endcase
         end
         PHASE_PAD: begin
            pad_left = pad_left - 2'd1;
            if (pad_left == 2'd0)
               phase = PHASE_PIXEL;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_parse();
         decoded_results.delete();
      end else begin
         if (req_valid && req_ready)
            decode_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (decoded_results.size() == 0) begin
               $error("result transfer with nothing predicted: 0x%0h", rsp_payload);
               fail_count++;
            end else begin
               want = decoded_results.pop_front();
               check_field("status", want.status, rsp_payload.status);
               check_field("red", want.red, rsp_payload.red);
               check_field("green", want.green, rsp_payload.green);
               check_field("blue", want.blue, rsp_payload.blue);
               check_field("row_index", want.row_index, rsp_payload.row_index);
               check_field("column_index", want.column_index, rsp_payload.column_index);
               check_field("last_pixel", want.last_pixel, rsp_payload.last_pixel);
            end
         end
      end
      failures    <= fail_count;
      outstanding <= decoded_results.size();
   end

endmodule

// ----- verif/bmp24_stream_decoder_unit_test.sv -----
// Testbench top for the BMP decoder: byte stream stimulus, idling, pressure and verdict.
`timescale 1ns / 100ps
module bmp24_stream_decoder_unit_test;
   import bmp24_pkg::*;

   localparam int RESET_CYCLES = 6;
   localparam int HOLD_CYCLES  = 80;    // long receiver hold-off, fills the output queue
   localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer on either channel
   localparam int DRAIN_CYCLES = 10;    // extra wait after the drain, before the verdict
   localparam int RANDOM_BYTES = 40;    // per idling phase, four phases

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int failures;
   int outstanding;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int quiet_cycles = 0;
   int bytes_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bmp24_stream_decoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   bmp24_decode_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Result side: stall at the current rate, or hold ready low for a long
   // stretch when the stimulus asks for one. The request counter is written
   // with a nonblocking assignment, so this loop sees it at the following edge.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: end the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one byte; idle first at the current rate. Valid is only lowered
   // while idling, so back-to-back bytes keep it high. Called at a rising
   // edge; returns at the edge where the transfer took place.
   task automatic put_byte(input logic [7:0] value, input logic sof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                 <= 1'b1;
      req_payload.data_byte     <= value;
      req_payload.start_of_file <= sof;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Bytes of pixel data plus row pad for a whole image.
   function automatic int image_bytes(input int width, input int height);
      return height * (3 * width + (width % 4));
   endfunction

   // Send a header (possibly cut short) followed by random body bytes.
   // Only the dimension and depth fields are fixed; every other header byte
   // is random, since the decoder must ignore it.
   task automatic send_bmp(input logic [31:0] width, input logic [31:0] height,
                           input logic [15:0] depth, input logic sof,
                           input int header_len, input int body_len);
      logic [7:0]  value;
      logic [5:0]  pos;
      for (int i = 0; i < header_len; i++) begin
         pos = 6'(i);
         value = 8'($urandom_range(255));
         if (pos >= WIDTH_FIRST && pos <= WIDTH_LAST)
            value = width[8 * (pos - WIDTH_FIRST) +: 8];
         else if (pos >= HEIGHT_FIRST && pos <= HEIGHT_LAST)
            value = height[8 * (pos - HEIGHT_FIRST) +: 8];
         else if (pos >= DEPTH_LOW && pos <= DEPTH_HIGH)
            value = depth[8 * (pos - DEPTH_LOW) +: 8];
         put_byte(value, sof && i == 0);
      end
      for (int i = 0; i < body_len; i++)
         put_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // One random file: mostly well-formed small images, some cut short,
   // some with a bad format or empty, a few with a broken header or no mark.
   task automatic send_random_file();
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] depth;
      int          pick;
      int          hdr_len;
      int          body_len;
      width  = $urandom_range(1, 6);
      height = $urandom_range(1, 3);
      depth  = DEPTH_24;
      hdr_len = 54;
      pick = $urandom_range(99);
      if (pick < 6)
         depth = 16'($urandom_range(65535));
      else if (pick < 10)
         width = $urandom;
      else if (pick < 13)
         height = 0;
      else if (pick < 16)
         width = $urandom_range(10, 20);
      if (pick < 13)
         body_len = $urandom_range(8);
      else if (pick < 28)
         body_len = $urandom_range(image_bytes(width, height) - 1);
      else
         body_len = image_bytes(width, height) + $urandom_range(3);
      if (pick >= 95) begin
         hdr_len  = $urandom_range(1, 53);
         body_len = 0;
      end
      send_bmp(width, height, depth, $urandom_range(9) != 0, hdr_len, body_len);
   endtask

   // Lower valid and hold until every predicted result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int stop_at;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling.
      // Pressure, with no start mark after reset so the first bytes still
      // form a header: hold the receiver off while bytes keep coming, so the
      // output queue fills and the input stalls; then pause until drained.
      // A width of five gives one pad byte per row.
      hold_requests <= hold_requests + 1;
      send_bmp(5, 2, DEPTH_24, 1'b0, 54, image_bytes(5, 2));
      drain();
      // Width one past the widest that fits: error result, body dropped.
      send_bmp(32'h10000, 1, DEPTH_24, 1'b1, 54, 3);
      // Tallest image that still fits, cut after two rows.
      send_bmp(1, 32'hFFFF, DEPTH_24, 1'b1, 54, 2 * 4);

      // Random part over the idling phases: none, sender, receiver, both.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 10 : 0;
         rsp_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 10 : 0;
         stop_at = bytes_sent + RANDOM_BYTES;
         while (bytes_sent < stop_at)
            send_random_file();
         if (ph == 1)
            drain();
      end

      // Wind down: wait for the last results, then let the bench settle.
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/bmp24_pkg.sv
rtl/core/bmp24_parser.sv
rtl/core/bmp24_rsp_queue.sv
rtl/core/bmp24_stream_decoder_unit.sv
verif/bmp24_decode_checker.sv
verif/bmp24_stream_decoder_unit_test.sv
